// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the slot pool allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property check on the rising clock edge, disabled while reset is high.
`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)

`endif

`endif

// ----- design/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Item types, operation codes and status codes shared by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  localparam int HANDLE_W = 9;
  localparam int LIMIT_W  = 9;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] handle;
  } cmd_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] new_handle;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] live_slots;
  } res_item_t;

endpackage

`default_nettype wire

// ----- design/spa_ram.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/slot_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator
// Hands out, checks and recycles handles over a fixed set of slots.
// ----------------------------------------------------------------------------
// For each command item the live-bit memory and the free stack memory are
// first read (both are synchronous RAMs with a registered read port); then
// the allocator decides and writes both memories back. Because the memory
// read is followed by a read-modify-write of the same memories, a new item
// is not taken before the previous one is written back. A finished result
// sits in an output register, so a new command item is taken while the
// previous result is still waiting downstream; only when that register is
// still held by a stall does the write-back wait. An
// insert pops the most recently freed slot, or else appends the next slot
// never used, and returns slot index plus one; it reports pool full with a
// null handle when neither is possible. A remove checks the handle, clears
// the live bit and pushes the slot onto the free stack. A query reports
// whether the handle names a live slot; the unused function code acts as a
// query. Live bits need no clearing pass after reset: slots are appended in
// order, so every slot at or above the count of slots ever appended (live
// plus freed) reads as not live, and the block is ready right after reset.
// The slot limit register is written through its own port, which is always
// ready, and should only be changed while the allocator is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slot_pool_allocator
  import spa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire cmd_item_t            cmd,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_item_t                 res,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [LIMIT_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  // Working width for compares, wide enough for handles and counts.
  localparam int W     = (CNT_W > HANDLE_W) ? CNT_W + 1 : HANDLE_W + 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t               state;
  logic [LIMIT_W-1:0]   slot_limit;
  logic [CNT_W-1:0]     live_count;
  logic [CNT_W-1:0]     free_depth;
  logic [1:0]           func_q;
  logic                 hnull_q;
  logic [W-1:0]         hidx_q;

  logic [CNT_W-1:0]     live_count_next;
  logic [CNT_W-1:0]     free_depth_next;
  res_item_t            res_next;

  logic                 accept;
  logic                 commit;
  logic [W-1:0]         eff_limit;
  logic [W-1:0]         high_mark;
  logic [W-1:0]         hidx_in;
  logic [CNT_W-1:0]     depth_minus_one;
  logic [W-1:0]         ins_idx;
  logic [W-1:0]         ins_handle;
  logic [W-1:0]         live_slots_w;
  logic                 has_free;
  logic                 ins_ok;
  logic                 h_ok;
  logic                 is_ins;
  logic                 is_rm;

  logic                 live_rdata;
  logic                 live_we;
  logic [IDX_W-1:0]     live_waddr;
  logic [IDX_W-1:0]     stack_rdata;
  logic                 stack_we;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = cmd_valid && !cmd_stall;
  assign commit    = (state == S_EXEC) && !(res_valid && res_stall);

  // Slot index named by the incoming handle; a null handle wraps and is
  // caught by the null flag.
  assign hidx_in         = W'(cmd.handle) - W'(1);
  assign depth_minus_one = free_depth - CNT_W'(1);

  spa_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (is_ins),
    .re    (accept),
    .raddr (hidx_in[IDX_W-1:0]),
    .rdata (live_rdata)
  );

  spa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_free_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (free_depth[IDX_W-1:0]),
    .wdata (hidx_q[IDX_W-1:0]),
    .re    (accept),
    .raddr (depth_minus_one[IDX_W-1:0]),
    .rdata (stack_rdata)
  );

  always_comb begin
    eff_limit = (W'(slot_limit) < W'(SLOTS)) ? W'(slot_limit) : W'(SLOTS);
    high_mark = W'(live_count) + W'(free_depth);
    is_ins    = (func_q == FUNC_INSERT);
    is_rm     = (func_q == FUNC_REMOVE);
    has_free  = (free_depth != '0);
    ins_ok    = has_free || (W'(live_count) < eff_limit);
    ins_idx   = has_free ? W'(stack_rdata) : W'(live_count);
    ins_handle = ins_idx + W'(1);
    // Slots at or above the high mark were never appended and are not live.
    h_ok      = !hnull_q && (hidx_q < eff_limit) && (hidx_q < high_mark) && live_rdata;

    live_we    = commit && ((is_ins && ins_ok) || (is_rm && h_ok));
    live_waddr = is_ins ? ins_idx[IDX_W-1:0] : hidx_q[IDX_W-1:0];
    stack_we   = commit && is_rm && h_ok;

    live_count_next = live_count;
    free_depth_next = free_depth;
    res_next.new_handle = '0;
    res_next.status     = ST_OK;
    if (is_ins) begin
      if (ins_ok) begin
        live_count_next     = live_count + CNT_W'(1);
        res_next.new_handle = ins_handle[HANDLE_W-1:0];
        if (has_free) begin
          free_depth_next = free_depth - CNT_W'(1);
        end
      end else begin
        res_next.status = ST_FULL;
      end
    end else if (is_rm) begin
      if (h_ok) begin
        live_count_next = live_count - CNT_W'(1);
        free_depth_next = free_depth + CNT_W'(1);
      end else begin
        res_next.status = ST_INVALID;
      end
    end else begin
      res_next.status = h_ok ? ST_OK : ST_INVALID;
    end
    live_slots_w        = W'(live_count_next);
    res_next.live_slots = live_slots_w[HANDLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      live_count <= '0;
      free_depth <= '0;
      slot_limit <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slot_limit <= cfg_data;
      end
      // A new result refills the register in the same cycle the old one leaves.
      if (res_valid && !res_stall && !commit) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_q  <= cmd.func;
            hnull_q <= (cmd.handle == '0);
            hidx_q  <= hidx_in;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            live_count <= live_count_next;
            free_depth <= free_depth_next;
            res        <= res_next;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Live plus freed slots never exceed the pool.
  `ASSERT_PROP(a_high_mark, clk, rst, high_mark <= W'(SLOTS), "slot high mark beyond pool")
  // A successful insert raises the live count by exactly one.
  `ASSERT_PROP(a_ins_count, clk, rst,
               (commit && is_ins && ins_ok) |=> (live_count == $past(live_count) + CNT_W'(1)),
               "insert count step wrong")
  // A successful remove pushes exactly one slot.
  `ASSERT_PROP(a_rm_push, clk, rst,
               (commit && is_rm && h_ok) |=> (free_depth == $past(free_depth) + CNT_W'(1)),
               "remove push step wrong")
  // The result register is never overwritten while it is held by a stall.
  `ASSERT_NEVER(a_no_overwrite, clk, rst, commit && res_valid && res_stall,
                "result overwritten under stall")

endmodule

`default_nettype wire

// ----- verif/slot_pool_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives insert, remove and query items into the allocator under random
// idling on both channels, predicts every result with a behavioral model of
// the pool, and checks the results in order while the slot limit moves
// through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module slot_pool_allocator_tb;
  import spa_pkg::*;

  localparam int POOL_SLOTS   = 256;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_PRINTED  = 100;

  // The pool model exists twice. The checker copy advances only on items
  // that the block accepts; the planner copy runs ahead while a phase is
  // built, so that removes and queries can aim at slots that will be live.
  localparam int CHECKER = 0;
  localparam int PLANNER = 1;

  // Function code 3 has no name in the package; the block treats it as a query.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  cmd_item_t          cmd       = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  res_item_t          res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  slot_pool_allocator #(
    .SLOTS(POOL_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pool state, one copy per model instance.
  bit          live_bits  [2][POOL_SLOTS];
  logic [7:0]  free_slots [2][POOL_SLOTS];
  int unsigned free_depth [2];
  int unsigned live_count [2];
  int unsigned pool_limit [2];

  cmd_item_t   cmd_backlog[$];      // items waiting to be driven
  res_item_t   awaited_results[$];  // predicted results, oldest first

  int send_gap  = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;

  int unsigned cycle_count    = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned full_results   = 0;
  int unsigned invalid_results = 0;
  int unsigned limit_writes   = 0;
  int unsigned mismatch_count = 0;

  // Slots beyond the available memory never count, and a limit of zero
  // leaves no valid handle at all.
  function automatic int unsigned eff_limit(int unsigned m);
    return (pool_limit[m] < POOL_SLOTS) ? pool_limit[m] : POOL_SLOTS;
  endfunction

  function automatic bit handle_live(int unsigned m, logic [HANDLE_W-1:0] h);
    if (h == '0) return 1'b0;
    if (h - 1 >= eff_limit(m)) return 1'b0;
    return live_bits[m][h - 1];
  endfunction

  // One allocator operation on model copy m; returns the result item it gives.
  function automatic res_item_t pool_step(int unsigned m, cmd_item_t c);
    res_item_t   r;
    int unsigned slot;
    bit          got;
    r        = '0;
    r.status = ST_OK;
    got      = 1'b1;
    slot     = 0;
    if (c.func == FUNC_INSERT) begin
      // A recycled slot wins over a fresh one, even when it now lies beyond
      // a lowered limit. Live plus freed slots equals the slots ever used,
      // so a fresh slot is always the one at index live_count.
      if (free_depth[m] > 0) begin
        free_depth[m]--;
        slot = free_slots[m][free_depth[m]];
      end else if (live_count[m] < eff_limit(m)) begin
        slot = live_count[m];
      end else begin
        got = 1'b0;
      end
      if (got) begin
        live_bits[m][slot] = 1'b1;
        live_count[m]++;
        r.new_handle = slot + 1;
      end else begin
        r.status = ST_FULL;
      end
    end else if (c.func == FUNC_REMOVE) begin
      if (handle_live(m, c.handle) && free_depth[m] < POOL_SLOTS) begin
        slot = c.handle - 1;
        live_bits[m][slot] = 1'b0;
        free_slots[m][free_depth[m]] = slot[7:0];
        free_depth[m]++;
        if (live_count[m] > 0) live_count[m]--;
      end else begin
        // A bad handle leaves the pool untouched.
        r.status = ST_INVALID;
      end
    end else begin
      r.status = handle_live(m, c.handle) ? ST_OK : ST_INVALID;
    end
    r.live_slots = live_count[m][HANDLE_W-1:0];
    return r;
  endfunction

  function automatic void sync_planner();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      live_bits[PLANNER][i]  = live_bits[CHECKER][i];
      free_slots[PLANNER][i] = free_slots[CHECKER][i];
    end
    free_depth[PLANNER] = free_depth[CHECKER];
    live_count[PLANNER] = live_count[CHECKER];
    pool_limit[PLANNER] = pool_limit[CHECKER];
  endfunction

  function automatic void queue_cmd(logic [1:0] f, logic [HANDLE_W-1:0] h);
    cmd_item_t c;
    c.func   = f;
    c.handle = h;
    cmd_backlog.push_back(c);
    void'(pool_step(PLANNER, c));
  endfunction

  // Mostly a handle that the planner sees live, else the null handle, the
  // handles right at the limit, or anything the field can carry.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned used, r, slot;
    used = live_count[PLANNER] + free_depth[PLANNER];
    r    = $urandom_range(0, 99);
    slot = 0;
    if (r < 70 && live_count[PLANNER] > 0) begin
      for (int t = 0; t < 16; t++) begin
        slot = $urandom_range(0, used - 1);
        if (live_bits[PLANNER][slot]) break;
      end
      return slot + 1;
    end
    if (r < 78) return '0;
    if (r < 90) return eff_limit(PLANNER) + $urandom_range(0, 2);
    return $urandom_range(0, 511);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return 2;
      3: return LIMIT_RESET;
      4: return '1;
      5: return $urandom_range(257, 510);
      default: return $urandom_range(3, 255);
    endcase
  endfunction

  // Idle length for either channel: usually none or a few cycles, now and
  // then a long one, and from time to time a calm stretch with no idling.
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Command driver. An item is taken at an edge with valid high and stall
  // low; the checker model advances right there, so its order matches the
  // order in which the block sees the items.
  always @(posedge clk) begin : drive_cmd
    cmd_item_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        awaited_results.push_back(pool_step(CHECKER, cmd));
        items_accepted++;
      end
      // A stalled item holds its payload; otherwise the slot is free for
      // the next item once the idle gap after the last one has run out.
      if (!cmd_valid || !cmd_stall) begin
        if (send_gap > 0) begin
          cmd_valid <= 1'b0;
          send_gap--;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          cmd       <= nxt;
          cmd_valid <= 1'b1;
          send_gap = draw_gap(send_calm);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string what, res_item_t want, res_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t: %s expected handle %0d status %0d live %0d, got handle %0d status %0d live %0d",
               $time, what, want.new_handle, want.status, want.live_slots,
               got.new_handle, got.status, got.live_slots);
    end else if (mismatch_count == MAX_PRINTED + 1) begin
      $display("%0t: further mismatches are counted but not printed", $time);
    end
  endfunction

  // Result monitor and stall generator. The stall pattern runs on its own,
  // so stalls land both while a result waits and while the block computes.
  always @(posedge clk) begin : watch_res
    res_item_t want;
    int        g;
    if (rst) begin
      res_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result:", '0, res);
        end else begin
          want = awaited_results.pop_front();
          if (want.status == ST_FULL) full_results++;
          if (want.status == ST_INVALID) invalid_results++;
          if (res !== want) report_mismatch("result:", want, res);
        end
      end
      if (recv_hold > 0) begin
        res_stall <= 1'b1;
        recv_hold--;
      end else begin
        g = draw_gap(recv_calm);
        res_stall <= (g > 0);
        if (g > 0) recv_hold = g - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still awaited",
               $time, cycle_count, awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every item gives exactly one result, so the block is idle once nothing
  // is queued, nothing is offered and nothing is awaited. A short pause
  // follows so that the write-back of the last item has settled.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || cmd_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pool_limit[CHECKER] = value;
    pool_limit[PLANNER] = value;
    limit_writes++;
  endtask

  task automatic run_random_phase(int unsigned n_items, int unsigned insert_pct);
    int unsigned r;
    logic [1:0]  f;
    sync_planner();
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        f = FUNC_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        f = (r < 55) ? FUNC_REMOVE : (r < 90) ? FUNC_QUERY : FUNC_SPARE;
      end
      // The handle of an insert is ignored, so it carries random bits.
      queue_cmd(f, (f == FUNC_INSERT) ? HANDLE_W'($urandom_range(0, 511)) : pick_handle());
    end
  endtask

  initial begin : run_test
    int unsigned sent, len, pct;
    pool_limit[CHECKER] = LIMIT_RESET;
    pool_limit[PLANNER] = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset limit: null and unused handles, fresh appends, recycling in
    // last-freed-first order, double remove, the spare code and handles
    // beyond the slot range.
    @(negedge clk);
    queue_cmd(FUNC_QUERY,  9'd0);
    queue_cmd(FUNC_QUERY,  9'd256);
    queue_cmd(FUNC_REMOVE, 9'd0);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_INSERT, 9'd511);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_QUERY,  9'd2);
    queue_cmd(FUNC_SPARE,  9'd2);
    queue_cmd(FUNC_REMOVE, 9'd2);
    queue_cmd(FUNC_REMOVE, 9'd2);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_REMOVE, 9'd3);
    queue_cmd(FUNC_REMOVE, 9'd1);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_QUERY,  9'd511);
    queue_cmd(FUNC_REMOVE, 9'd257);
    wait_idle();

    // Lowered limit: the freed slot above it still comes back from the free
    // stack but reads as invalid, and the next insert finds the pool full.
    write_limit(9'd1);
    @(negedge clk);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_QUERY,  9'd3);
    queue_cmd(FUNC_REMOVE, 9'd3);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_QUERY,  9'd1);
    wait_idle();

    // A limit of zero fails every insert and rejects every handle.
    write_limit(9'd0);
    @(negedge clk);
    queue_cmd(FUNC_QUERY,  9'd1);
    queue_cmd(FUNC_INSERT, 9'd0);
    queue_cmd(FUNC_REMOVE, 9'd1);

    // The first random phase fills the whole pool at the reset limit; the
    // rest move through random limits with varying insert pressure.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (sent == 0) begin
        write_limit(LIMIT_RESET);
        len = 360;
        pct = 90;
      end else begin
        write_limit(pick_limit());
        len = $urandom_range(40, 220);
        case ($urandom_range(0, 2))
          0: pct = 25;
          1: pct = 50;
          default: pct = 75;
        endcase
      end
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      @(negedge clk);
      run_random_phase(len, pct);
      sent += len;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d items under %0d limit writes in %0d cycles.",
             items_accepted, limit_writes, cycle_count);
    $display("Checked %0d results: %0d with a full pool, %0d with a rejected handle.",
             results_seen, full_results, invalid_results);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
